// ----- src/ppn_pkg.sv -----
// ----------------------------------------------------------------------------
// ppn_pkg
// shared types and constants of the newell polygon plane unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppn_pkg;

	localparam int COORD_W   = 16;
	localparam int PROD_W    = 34;
	localparam int ACC_W     = 48;
	localparam int NORM_W    = 16;
	localparam int OFFSET_W  = 24;
	localparam int FRAC_W    = 24;
	localparam int SQ_W      = 50;
	localparam int ROOT_W    = 25;
	localparam int REM_W     = 27;
	localparam int QUO_W     = 15;
	localparam int DREM_W    = 26;
	localparam int NUM_W     = 39;
	localparam int DOT_W     = 34;
	localparam int THR_W     = 16;
	localparam int CNT_W     = 5;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int SQRT_STEPS = 25;
	localparam int AXES      = 3;

	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_EDGE_MUL,
		OP_CLOSE_MUL,
		OP_EDGE_ADD,
		OP_CLOSE_ADD,
		OP_MAG,
		OP_CHECK,
		OP_SHIFT,
		OP_SQ_MUL,
		OP_SQ_SUM,
		OP_SQRT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_DOT_MUL,
		OP_DOT_SUM
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] comp;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic degen;
		logic norm_done;
	} status_t;

endpackage

`default_nettype wire

// ----- src/ppn_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppn_ctrl
// sequencer: vertex accumulation, normalization steps and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppn_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_last,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire ppn_pkg::status_t status,
	output ppn_pkg::cmd_t         cmd
);
	import ppn_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_EDGE_MUL, S_EDGE_ADD, S_CLOSE_MUL, S_CLOSE_ADD, S_MAG, S_CHECK,
		S_SHIFT, S_SQ_MUL, S_SQ_SUM, S_SQRT, S_DIV_INIT, S_DIV_STEP, S_DIV_END,
		S_DOT_MUL, S_DOT_SUM, S_EMIT
	} state_t;

	state_t           state_q;
	logic             last_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       comp_q;
	logic             out_valid_q;
	logic             emit;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.comp = comp_q;
		cmd.emit = emit;
		unique case (state_q)
			S_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_EDGE_MUL:  cmd.op = OP_EDGE_MUL;
			S_EDGE_ADD:  cmd.op = OP_EDGE_ADD;
			S_CLOSE_MUL: cmd.op = OP_CLOSE_MUL;
			S_CLOSE_ADD: cmd.op = OP_CLOSE_ADD;
			S_MAG:       cmd.op = OP_MAG;
			S_CHECK:     cmd.op = OP_CHECK;
			S_SHIFT:     cmd.op = (status.degen || status.norm_done) ? OP_NONE : OP_SHIFT;
			S_SQ_MUL:    cmd.op = OP_SQ_MUL;
			S_SQ_SUM:    cmd.op = OP_SQ_SUM;
			S_SQRT:      cmd.op = OP_SQRT;
			S_DIV_INIT:  cmd.op = OP_DIV_INIT;
			S_DIV_STEP:  cmd.op = OP_DIV_STEP;
			S_DIV_END:   cmd.op = OP_DIV_END;
			S_DOT_MUL:   cmd.op = OP_DOT_MUL;
			S_DOT_SUM:   cmd.op = OP_DOT_SUM;
			S_EMIT:      cmd.op = OP_NONE;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			comp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= in_last;
						if (status.active)
							state_q <= S_EDGE_MUL;
						else if (in_last)
							state_q <= S_CLOSE_MUL;
					end
				end
				S_EDGE_MUL:  state_q <= S_EDGE_ADD;
				S_EDGE_ADD:  state_q <= last_q ? S_CLOSE_MUL : S_IDLE;
				S_CLOSE_MUL: state_q <= S_CLOSE_ADD;
				S_CLOSE_ADD: state_q <= S_MAG;
				S_MAG:       state_q <= S_CHECK;
				S_CHECK:     state_q <= S_SHIFT;
				S_SHIFT: begin
					if (status.degen)
						state_q <= S_DOT_MUL;
					else if (status.norm_done)
						state_q <= S_SQ_MUL;
				end
				S_SQ_MUL: state_q <= S_SQ_SUM;
				S_SQ_SUM: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
						comp_q  <= '0;
						state_q <= S_DIV_INIT;
					end
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV_STEP;
				end
				S_DIV_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUO_W - 1))
						state_q <= S_DIV_END;
				end
				S_DIV_END: begin
					if (comp_q == 2'(AXES - 1)) begin
						state_q <= S_DOT_MUL;
					end else begin
						comp_q  <= comp_q + 1'b1;
						state_q <= S_DIV_INIT;
					end
				end
				S_DOT_MUL: state_q <= S_DOT_SUM;
				S_DOT_SUM: state_q <= S_EMIT;
				S_EMIT:    if (emit) state_q <= S_IDLE;
				default:   state_q <= S_IDLE;
			endcase
		end
	end

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result not presented after emit");
	a_sqrt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> cnt_q < CNT_W'(SQRT_STEPS))
		else $error("square root step count overrun");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV_STEP |-> (cnt_q < CNT_W'(QUO_W)) && (comp_q < 2'(AXES)))
		else $error("divider step or component overrun");
	a_mag_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAG |-> $past(state_q) == S_CLOSE_ADD)
		else $error("normalization started without closing edge");

endmodule

`default_nettype wire

// ----- src/ppn_datapath.sv -----
// ----------------------------------------------------------------------------
// ppn_datapath
// newell accumulators, normalization, shared sqrt/divide and plane offset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppn_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ppn_pkg::cmd_t                       cmd,
	output ppn_pkg::status_t                         status,
	input  wire logic [ppn_pkg::THR_W-1:0]           threshold,
	input  wire logic signed [ppn_pkg::COORD_W-1:0]  vx,
	input  wire logic signed [ppn_pkg::COORD_W-1:0]  vy,
	input  wire logic signed [ppn_pkg::COORD_W-1:0]  vz,
	output logic signed [ppn_pkg::NORM_W-1:0]        nx,
	output logic signed [ppn_pkg::NORM_W-1:0]        ny,
	output logic signed [ppn_pkg::NORM_W-1:0]        nz,
	output logic signed [ppn_pkg::OFFSET_W-1:0]      offset,
	output logic                                     degen
);
	import ppn_pkg::*;

	logic signed [COORD_W-1:0] cur_q   [AXES];
	logic signed [COORD_W-1:0] first_q [AXES];
	logic signed [COORD_W-1:0] prev_q  [AXES];
	logic                      inside_q;
	logic signed [PROD_W-1:0]  prod_q  [AXES];
	logic [ACC_W-1:0]          sum_q   [AXES];
	logic [ACC_W-1:0]          mag_q   [AXES];
	logic [AXES-1:0]           neg_q;
	logic [ACC_W-1:0]          m_q;
	logic                      degen_q;
	logic [ACC_W-1:0]          sq_part_q [AXES];
	logic [SQ_W-1:0]           sq_q;
	logic [ROOT_W-1:0]         root_q;
	logic [REM_W-1:0]          rem_q;
	logic [DREM_W-1:0]         drem_q;
	logic [QUO_W-1:0]          dbits_q;
	logic [QUO_W-1:0]          quo_q;
	logic signed [NORM_W-1:0]  n_q [AXES];
	logic signed [31:0]        dp_q [AXES];
	logic signed [OFFSET_W-1:0] d_q;
	logic signed [NORM_W-1:0]  nx_q, ny_q, nz_q;
	logic signed [OFFSET_W-1:0] off_q;
	logic                      dg_q;

	// edge term operands
	logic signed [COORD_W-1:0] ea [AXES];
	logic signed [COORD_W-1:0] eb [AXES];
	logic signed [COORD_W:0]   s_yz, s_zx, s_xy, d_yz, d_zx, d_xy;
	logic [ACC_W-1:0]          mx;
	logic [17:0]               sq8;
	logic [REM_W+1:0]          rem_n, trial;
	logic [NUM_W-1:0]          num;
	logic [DREM_W:0]           dt;
	logic [NORM_W-1:0]         q16;
	logic signed [DOT_W-1:0]   dot, negd, absd, rd;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			ea[i] = prev_q[i];
			eb[i] = (cmd.op == OP_CLOSE_MUL) ? first_q[i] : cur_q[i];
		end
		s_yz = {ea[2][COORD_W-1], ea[2]} + {eb[2][COORD_W-1], eb[2]};
		d_yz = {eb[1][COORD_W-1], eb[1]} - {ea[1][COORD_W-1], ea[1]};
		s_zx = {ea[0][COORD_W-1], ea[0]} + {eb[0][COORD_W-1], eb[0]};
		d_zx = {eb[2][COORD_W-1], eb[2]} - {ea[2][COORD_W-1], ea[2]};
		s_xy = {ea[1][COORD_W-1], ea[1]} + {eb[1][COORD_W-1], eb[1]};
		d_xy = {eb[0][COORD_W-1], eb[0]} - {ea[0][COORD_W-1], ea[0]};

		mx = mag_q[0];
		if (mag_q[1] > mx) mx = mag_q[1];
		if (mag_q[2] > mx) mx = mag_q[2];
		sq8 = 18'(mag_q[0][7:0] * mag_q[0][7:0]) + 18'(mag_q[1][7:0] * mag_q[1][7:0])
			+ 18'(mag_q[2][7:0] * mag_q[2][7:0]);

		rem_n = {rem_q, sq_q[SQ_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};

		num = {1'b0, mag_q[cmd.comp][FRAC_W-1:0], 14'b0} + NUM_W'(root_q >> 1);
		dt  = {drem_q, dbits_q[QUO_W-1]};
		q16 = {1'b0, quo_q};

		dot  = DOT_W'(dp_q[0]) + DOT_W'(dp_q[1]) + DOT_W'(dp_q[2]);
		negd = -dot;
		absd = negd[DOT_W-1] ? -negd : negd;
		rd   = (absd + DOT_W'(8192)) >>> 14;
		if (negd[DOT_W-1]) rd = -rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
		end else begin
			if (cmd.op == OP_LOAD)
				inside_q <= 1'b1;
			else if (cmd.op == OP_MAG)
				inside_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_NONE: ;
			OP_LOAD: begin
				cur_q[0] <= vx;
				cur_q[1] <= vy;
				cur_q[2] <= vz;
				if (!inside_q) begin
					first_q[0] <= vx;
					first_q[1] <= vy;
					first_q[2] <= vz;
					prev_q[0]  <= vx;
					prev_q[1]  <= vy;
					prev_q[2]  <= vz;
					for (int i = 0; i < AXES; i++)
						sum_q[i] <= '0;
				end
			end
			OP_EDGE_MUL, OP_CLOSE_MUL: begin
				prod_q[0] <= s_yz * d_yz;
				prod_q[1] <= s_zx * d_zx;
				prod_q[2] <= s_xy * d_xy;
			end
			OP_EDGE_ADD, OP_CLOSE_ADD: begin
				for (int i = 0; i < AXES; i++)
					sum_q[i] <= sum_q[i] + {{(ACC_W-PROD_W){prod_q[i][PROD_W-1]}}, prod_q[i]};
				if (cmd.op == OP_EDGE_ADD)
					for (int i = 0; i < AXES; i++)
						prev_q[i] <= cur_q[i];
			end
			OP_MAG: begin
				for (int i = 0; i < AXES; i++) begin
					neg_q[i] <= sum_q[i][ACC_W-1];
					mag_q[i] <= sum_q[i][ACC_W-1] ? (~sum_q[i] + 1'b1) : sum_q[i];
				end
			end
			OP_CHECK: begin
				m_q     <= mx;
				degen_q <= (mx == '0) || ((mx < ACC_W'(256)) && (sq8 < {2'b00, threshold}));
				for (int i = 0; i < AXES; i++)
					n_q[i] <= '0;
			end
			OP_SHIFT: begin
				if (|m_q[ACC_W-1:FRAC_W]) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < AXES; i++)
						mag_q[i] <= mag_q[i] >> 1;
				end else begin
					m_q <= m_q << 1;
					for (int i = 0; i < AXES; i++)
						mag_q[i] <= mag_q[i] << 1;
				end
			end
			OP_SQ_MUL: begin
				for (int i = 0; i < AXES; i++)
					sq_part_q[i] <= mag_q[i][FRAC_W-1:0] * mag_q[i][FRAC_W-1:0];
			end
			OP_SQ_SUM: begin
				sq_q   <= SQ_W'(sq_part_q[0]) + SQ_W'(sq_part_q[1]) + SQ_W'(sq_part_q[2]);
				root_q <= '0;
				rem_q  <= '0;
			end
			OP_SQRT: begin
				sq_q <= sq_q << 2;
				if (rem_n >= trial) begin
					rem_q  <= REM_W'(rem_n - trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= REM_W'(rem_n);
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			OP_DIV_INIT: begin
				drem_q  <= DREM_W'(num[NUM_W-1:QUO_W]);
				dbits_q <= num[QUO_W-1:0];
				quo_q   <= '0;
			end
			OP_DIV_STEP: begin
				dbits_q <= dbits_q << 1;
				if (dt >= {2'b00, root_q}) begin
					drem_q <= DREM_W'(dt - {2'b00, root_q});
					quo_q  <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					drem_q <= DREM_W'(dt);
					quo_q  <= {quo_q[QUO_W-2:0], 1'b0};
				end
			end
			OP_DIV_END: begin
				n_q[cmd.comp] <= neg_q[cmd.comp] ? -$signed(q16) : $signed(q16);
			end
			OP_DOT_MUL: begin
				for (int i = 0; i < AXES; i++)
					dp_q[i] <= n_q[i] * first_q[i];
			end
			OP_DOT_SUM: begin
				d_q <= OFFSET_W'(rd);
			end
			default: ;
		endcase
		if (cmd.emit) begin
			nx_q  <= n_q[0];
			ny_q  <= n_q[1];
			nz_q  <= n_q[2];
			off_q <= d_q;
			dg_q  <= degen_q;
		end
	end

	assign status.active    = inside_q;
	assign status.degen     = degen_q;
	assign status.norm_done = !(|m_q[ACC_W-1:FRAC_W]) && m_q[FRAC_W-1];

	assign nx     = nx_q;
	assign ny     = ny_q;
	assign nz     = nz_q;
	assign offset = off_q;
	assign degen  = dg_q;

endmodule

`default_nettype wire

// ----- src/polygon_plane_newell.sv -----
// ----------------------------------------------------------------------------
// polygon_plane_newell
// streaming newell-method polygon plane unit
// ----------------------------------------------------------------------------
// vertices of one polygon arrive as requests on the s_ channel, one per
// request, with s_tlast high on the final vertex. each polygon gives one
// result request on the m_ channel: unit normal (q1.14), plane offset d
// (signed 24-bit integer) and a degenerate flag in m_tuser.
// a vertex that is the first of a polygon is only loaded; any other vertex
// passes through load, edge products and accumulate. the final vertex adds
// the closing edge and runs normalization through the one-bit-per-cycle
// normalizing shifter (up to 24 steps), the 25-step square root and the
// 15-step divider shared by the three components. a degenerate polygon
// skips the shifter, square root and divider.
// the result waits in an output register; the next polygon's vertices are
// taken while it waits, and a stalled receiver only holds the block when the
// next result is ready to leave.
// reset clears the accumulators' ownership flag, empties the output register
// and sets degenerate_threshold (apb offset 0) back to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module polygon_plane_newell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// vertex requests
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [47:0]                   s_tdata,  // vertex_x, vertex_y, vertex_z
	input  wire logic                          s_tlast,  // last_vertex
	// result requests
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [71:0]                        m_tdata,  // normal_x, normal_y, normal_z, plane_offset
	output logic [0:0]                         m_tuser,  // degenerate
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ppn_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [ppn_pkg::DATA_W-1:0]    pwdata,
	output logic [ppn_pkg::DATA_W-1:0]         prdata,
	output logic                               pready
);
	import ppn_pkg::*;

	logic [THR_W-1:0]          threshold_q;
	cmd_t                      cmd;
	status_t                   status;
	logic signed [NORM_W-1:0]  nx, ny, nz;
	logic signed [OFFSET_W-1:0] offset;
	logic                      degen;

	// register i sits at byte offset 4*i, so paddr[2] is the register index
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? {{(DATA_W-THR_W){1'b0}}, threshold_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

	ppn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	ppn_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.threshold (threshold_q),
		.vx        (s_tdata[15:0]),
		.vy        (s_tdata[31:16]),
		.vz        (s_tdata[47:32]),
		.nx        (nx),
		.ny        (ny),
		.nz        (nz),
		.offset    (offset),
		.degen     (degen)
	);

	// results packed lowest field first
	assign m_tdata = {offset, nz, ny, nx};
	assign m_tuser = degen;

endmodule

`default_nettype wire

// ----- bench/tb_polygon_plane_newell.sv -----
// ----------------------------------------------------------------------------
// tb_polygon_plane_newell
// self-checking bench for the newell polygon plane unit
// ----------------------------------------------------------------------------
// polygons are streamed as vertex requests; a built-in predictor computes the
// unit normal, plane offset and degenerate flag of each closed polygon, and
// every result request is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_polygon_plane_newell;

	import ppn_pkg::*;

	typedef struct packed {
		logic        last;
		logic [15:0] z;
		logic [15:0] y;
		logic [15:0] x;
	} vertex_t;

	typedef struct {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic signed [23:0] offset;
		logic               degen;
	} plane_t;

	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic        pready;

	polygon_plane_newell uut (.*);

	// clock, period 2 ns
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	vertex_t vertex_queue[$];
	plane_t  plane_queue[$];
	int      errors = 0;
	int      planes_seen = 0;
	int      degen_seen = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      hold_cycles = 0;
	int      quiet_cycles = 0;

	// predictor state
	logic [15:0] threshold = 16'd1;
	logic signed [15:0] first_v[3];
	logic signed [15:0] prev_v[3];
	logic [47:0] acc_yz = '0;
	logic [47:0] acc_zx = '0;
	logic [47:0] acc_xy = '0;
	logic        in_poly = 1'b0;

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// one newell edge term per axis pair, wrapping at 48 bits
	task automatic add_newell_edge(input logic signed [15:0] p[3],
			input logic signed [15:0] c[3]);
		longint t;
		t = longint'(p[2] + c[2]) * longint'(c[1] - p[1]);
		acc_yz = acc_yz + t[47:0];
		t = longint'(p[0] + c[0]) * longint'(c[2] - p[2]);
		acc_zx = acc_zx + t[47:0];
		t = longint'(p[1] + c[1]) * longint'(c[0] - p[0]);
		acc_xy = acc_xy + t[47:0];
	endtask

	task automatic predict_vertex(input vertex_t vin);
		logic signed [15:0] v[3];
		longint s[3];
		logic [63:0] mag[3];
		logic [63:0] m, sq, r;
		longint n[3];
		longint dot, d;
		logic   degen;
		plane_t p;
		v[0] = vin.x; v[1] = vin.y; v[2] = vin.z;
		if (!in_poly) begin
			first_v = v;
			in_poly = 1'b1;
		end else begin
			add_newell_edge(prev_v, v);
		end
		prev_v = v;
		if (!vin.last) return;
		add_newell_edge(prev_v, first_v);
		s[0] = longint'(signed'(acc_yz));
		s[1] = longint'(signed'(acc_zx));
		s[2] = longint'(signed'(acc_xy));
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = s[i] < 0 ? -s[i] : s[i];
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) degen = 1'b1;
		else if (m >= 256) degen = 1'b0;
		else degen = (mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2]) < threshold;
		n[0] = 0; n[1] = 0; n[2] = 0;
		if (!degen) begin
			while (m >= (64'd1 << 24)) begin
				m >>= 1;
				for (int i = 0; i < 3; i++) mag[i] >>= 1;
			end
			while (m < (64'd1 << 23)) begin
				m <<= 1;
				for (int i = 0; i < 3; i++) mag[i] <<= 1;
			end
			sq = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
			r = int_sqrt(sq);
			for (int i = 0; i < 3; i++) begin
				n[i] = longint'(((mag[i] << 14) + (r >> 1)) / r);
				if (s[i] < 0) n[i] = -n[i];
			end
		end
		dot = -(n[0]*first_v[0] + n[1]*first_v[1] + n[2]*first_v[2]);
		if (dot >= 0) d = (dot + 8192) >>> 14;
		else d = -((-dot + 8192) >>> 14);
		p.nx = n[0][15:0]; p.ny = n[1][15:0]; p.nz = n[2][15:0];
		p.offset = d[23:0];
		p.degen = degen;
		plane_queue.push_back(p);
		acc_yz = 0; acc_zx = 0; acc_xy = 0;
		in_poly = 1'b0;
		for (int i = 0; i < 3; i++) begin
			first_v[i] = 0;
			prev_v[i] = 0;
		end
	endtask

	// driver: offers the head of the vertex queue, idles at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_vertex({s_tlast, s_tdata[47:32], s_tdata[31:16], s_tdata[15:0]});
				void'(vertex_queue.pop_front());
			end
			if ((!s_tvalid || s_tready) || !s_tvalid) begin
				if (s_tvalid && !s_tready) begin
					// hold the current request
				end else if (vertex_queue.size() > (s_tvalid && s_tready ? 0 : 0)
						&& $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= vertex_queue[0][47:0];
					s_tlast  <= vertex_queue[0].last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver ready: random stalls, or a long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: compares each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			plane_t e;
			if (plane_queue.size() == 0) begin
				$error("result with no polygon pending");
				errors++;
			end else begin
				e = plane_queue.pop_front();
				planes_seen++;
				if (e.degen) degen_seen++;
				if (m_tdata[15:0] !== e.nx) begin
					$error("normal_x exp %0d got %0d", e.nx, $signed(m_tdata[15:0]));
					errors++;
				end
				if (m_tdata[31:16] !== e.ny) begin
					$error("normal_y exp %0d got %0d", e.ny, $signed(m_tdata[31:16]));
					errors++;
				end
				if (m_tdata[47:32] !== e.nz) begin
					$error("normal_z exp %0d got %0d", e.nz, $signed(m_tdata[47:32]));
					errors++;
				end
				if (m_tdata[71:48] !== e.offset) begin
					$error("plane_offset exp %0d got %0d", e.offset,
						$signed(m_tdata[71:48]));
					errors++;
				end
				if (m_tuser[0] !== e.degen) begin
					$error("degenerate exp %0d got %0d", e.degen, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted request and no apb select
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_threshold(input logic [15:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= '0; pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		threshold = value;
	endtask

	task automatic push_vertex(input int x, input int y, input int z, input bit last);
		vertex_t v;
		v.x = x[15:0]; v.y = y[15:0]; v.z = z[15:0]; v.last = last;
		vertex_queue.push_back(v);
	endtask

	// random polygon: mostly small coordinates, sometimes full range
	task automatic push_polygon(input int n_verts, input bit wide);
		int span;
		for (int i = 0; i < n_verts; i++) begin
			span = wide ? 32767 : (1 << $urandom_range(1, 12));
			push_vertex($urandom_range(2*span) - span, $urandom_range(2*span) - span,
				$urandom_range(2*span) - span, i == n_verts - 1);
		end
	endtask

	// waits for every result, then lets the back end finish
	task automatic drain;
		wait (vertex_queue.size() == 0 && !s_tvalid && plane_queue.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	int sent;
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: degenerate and special shapes at reset threshold
		push_vertex(100, 200, 300, 1);                    // single vertex
		push_vertex(-32768, 32767, 0, 0);                 // two vertices
		push_vertex(32767, -32768, -1, 1);
		push_vertex(0, 0, 0, 0);                          // right triangle xy
		push_vertex(256, 0, 0, 0);
		push_vertex(0, 256, 0, 1);
		push_vertex(0, 0, 256, 0);                        // yz triangle off origin
		push_vertex(0, 256, 256, 0);
		push_vertex(0, 0, 512, 1);
		push_vertex(-32768, -32768, -32768, 0);           // extreme corners
		push_vertex(32767, -32768, 32767, 0);
		push_vertex(32767, 32767, -32768, 0);
		push_vertex(-32768, 32767, 32767, 1);
		push_vertex(0, 0, 0, 0);                          // tiny area
		push_vertex(1, 0, 0, 0);
		push_vertex(0, 1, 0, 1);
		drain();

		write_threshold(16'hFFFF);
		push_vertex(0, 0, 0, 0);                          // tiny area now degenerate
		push_vertex(3, 0, 0, 0);
		push_vertex(0, 5, 0, 1);
		push_polygon(4, 1'b1);
		drain();

		write_threshold(16'd0);
		push_vertex(0, 0, 0, 0);
		push_vertex(1, 0, 0, 0);
		push_vertex(0, 1, 0, 1);
		push_vertex(7, 7, 7, 0);                          // collinear, zero sums
		push_vertex(7, 7, 7, 1);
		drain();

		// pressure: receiver holds off while polygons keep coming
		hold_cycles = 3000;
		for (int i = 0; i < 8; i++) push_polygon(3, 1'b0);
		drain();

		// random phases
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 13 : (ph == 1 ? 54 : 0);
			recv_idle_pct = ph == 0 ? 54 : (ph == 1 ? 13 : 0);
			write_threshold(ph == 0 ? 16'd40 : (ph == 1 ? 16'd1000 : 16'd1));
			sent = 0;
			while (sent < 450) begin
				int nv;
				nv = $urandom_range(99) < 10 ? $urandom_range(1, 2) :
					($urandom_range(99) < 3 ? $urandom_range(40, 70) : $urandom_range(3, 8));
				push_polygon(nv, $urandom_range(99) < 20);
				sent += nv;
			end
			drain();
		end

		$display("covered %0d polygons, %0d degenerate, threshold at 0, 1, 40, 1000, max",
			planes_seen, degen_seen);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/ppn_pkg.sv
src/ppn_ctrl.sv
src/ppn_datapath.sv
src/polygon_plane_newell.sv
bench/tb_polygon_plane_newell.sv
